### rtl/trajectory_time_stamping_macros.svh
// Assertion macros used by the checker file.
`ifndef TRAJECTORY_TIME_STAMPING_MACROS_SVH
`define TRAJECTORY_TIME_STAMPING_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tts checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define TTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tts checker: next-cycle property failed");

`endif

### rtl/tts_pkg.sv
`default_nettype none

package tts_pkg;

    // Port field widths
    localparam int POS_W   = 32;
    localparam int SPD_W   = 24;
    localparam int FLOOR_W = 23;
    localparam int SEC_W   = 31;
    localparam int NS_W    = 30;

    // Internal datapath widths
    localparam int DIFF_W    = POS_W;
    localparam int SQ_W      = 2 * DIFF_W;
    localparam int SSQ_W     = SQ_W + 2;
    localparam int ROOT_W    = SSQ_W / 2;
    localparam int SREM_W    = ROOT_W + 1;
    localparam int DEN_W     = SPD_W + 1;
    localparam int SCALE_W   = 31;
    localparam int PROD_W    = 64;
    localparam int ELAPSED_W = SEC_W + SEC_W - 1;
    localparam int CNT_W     = 6;

    localparam logic [FLOOR_W-1:0]   MIN_SPEED_RST = 23'd512;
    localparam logic [SCALE_W-1:0]   SEG_SCALE     = 31'd2000000000;
    localparam logic [NS_W-1:0]      NS_PER_S      = 30'd1000000000;
    localparam logic [ELAPSED_W-1:0] ELAPSED_CAP   = 61'd2147483647999999999;

    // Step counts, loaded as count - 1
    localparam logic [CNT_W-1:0] MUL_CNT   = CNT_W'(DIFF_W - 1);
    localparam logic [CNT_W-1:0] SQRT_CNT  = CNT_W'(ROOT_W - 1);
    localparam logic [CNT_W-1:0] SCALE_CNT = CNT_W'(ROOT_W - 1);
    localparam logic [CNT_W-1:0] DIV_CNT   = CNT_W'(PROD_W - 1);
    localparam logic [CNT_W-1:0] SPLIT_CNT = CNT_W'(SEC_W - 1);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_MUL   = 10'b0000000010,
        ST_SUMSQ = 10'b0000000100,
        ST_SQRT  = 10'b0000001000,
        ST_SCALE = 10'b0000010000,
        ST_DIV   = 10'b0000100000,
        ST_ACC   = 10'b0001000000,
        ST_SAT   = 10'b0010000000,
        ST_SPLIT = 10'b0100000000,
        ST_DONE  = 10'b1000000000
    } state_t;

endpackage

`default_nettype wire

### rtl/trajectory_time_stamping.sv
// A later point passes squaring, sum of squares, root, scale multiply, divide, accumulate, saturate
// and seconds split; a first point goes straight to the split. One point at a time: the next is
// taken once the result is registered. The steps come from the bit-serial squarers (32 steps),
// the root (33), the scale multiply (33), the 64-step divide and the 31-step seconds split.
// Reset (synchronous, aresetn low): idle, output empty, previous point and elapsed time zero,
// min_speed 512.
`default_nettype none

module trajectory_time_stamping (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [tts_pkg::FLOOR_W-1:0]          cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_first,
    input  logic signed [tts_pkg::POS_W-1:0]     s_x_pos,
    input  logic signed [tts_pkg::POS_W-1:0]     s_y_pos,
    input  logic signed [tts_pkg::SPD_W-1:0]     s_speed,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [tts_pkg::SEC_W-1:0]            m_seconds,
    output logic [tts_pkg::NS_W-1:0]             m_nanoseconds
);
    import tts_pkg::*;

    // Control and architectural state
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   m_valid_reg, m_valid_next;
    logic [FLOOR_W-1:0]     min_speed_reg, min_speed_next;
    logic [POS_W-1:0]       prev_x_reg, prev_x_next;
    logic [POS_W-1:0]       prev_y_reg, prev_y_next;
    logic [SPD_W-1:0]       prev_speed_reg, prev_speed_next;
    logic [ELAPSED_W-1:0]   elapsed_reg, elapsed_next;

    // Datapath
    logic [DIFF_W-1:0]      dx_reg, dx_next;
    logic [DIFF_W-1:0]      dy_reg, dy_next;
    logic [SQ_W-1:0]        px_reg, px_next;
    logic [SQ_W-1:0]        py_reg, py_next;
    logic [DEN_W-1:0]       spd_sum_reg, spd_sum_next;
    logic [DEN_W-1:0]       den_reg, den_next;
    logic [SSQ_W-1:0]       sqv_reg, sqv_next;
    logic [ROOT_W-1:0]      root_reg, root_next;
    logic [SREM_W-1:0]      srem_reg, srem_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [DEN_W-1:0]       drem_reg, drem_next;
    logic [NS_W-1:0]        nsr_reg, nsr_next;
    logic [SEC_W-1:0]       sec_reg, sec_next;
    logic [SEC_W-1:0]       m_seconds_reg, m_seconds_next;
    logic [NS_W-1:0]        m_ns_reg, m_ns_next;

    // Combinational helpers
    logic [POS_W:0]         x_diff, y_diff;
    logic [DIFF_W-1:0]      x_abs, y_abs;
    logic [DIFF_W:0]        px_add, py_add;
    logic [SSQ_W-1:0]       ssq;
    logic [DEN_W-1:0]       spd_mag, two_floor;
    logic [FLOOR_W-1:0]     floor_v;
    logic [SREM_W+1:0]      s_try, s_trial;
    logic [SCALE_W:0]       sc_add;
    logic [DEN_W:0]         d_try;
    logic                   d_q;
    logic [ELAPSED_W-1:0]   el_sat;
    logic [NS_W:0]          sp_try;
    logic                   sp_q;
    logic                   s_xfer;

    assign s_ready       = (state_reg == ST_IDLE);
    assign s_xfer        = s_valid && s_ready;
    assign m_valid       = m_valid_reg;
    assign m_seconds     = m_seconds_reg;
    assign m_nanoseconds = m_ns_reg;

    always_comb begin
        x_diff = {s_x_pos[POS_W-1], s_x_pos} - {prev_x_reg[POS_W-1], prev_x_reg};
        y_diff = {s_y_pos[POS_W-1], s_y_pos} - {prev_y_reg[POS_W-1], prev_y_reg};
        x_abs  = x_diff[POS_W] ? DIFF_W'(-x_diff) : x_diff[DIFF_W-1:0];
        y_abs  = y_diff[POS_W] ? DIFF_W'(-y_diff) : y_diff[DIFF_W-1:0];

        px_add = {1'b0, px_reg[SQ_W-1:DIFF_W]} + {1'b0, dx_reg};
        py_add = {1'b0, py_reg[SQ_W-1:DIFF_W]} + {1'b0, dy_reg};

        ssq = {2'b00, px_reg} + {2'b00, py_reg};

        spd_mag   = spd_sum_reg[DEN_W-1] ? DEN_W'(-spd_sum_reg) : spd_sum_reg;
        floor_v   = (min_speed_reg == '0) ? FLOOR_W'(1) : min_speed_reg;
        two_floor = {1'b0, floor_v, 1'b0};

        s_try   = {srem_reg, sqv_reg[SSQ_W-1 -: 2]};
        s_trial = {1'b0, root_reg, 2'b01};

        sc_add = {1'b0, prod_reg[PROD_W-1:ROOT_W]} + {1'b0, SEG_SCALE};

        d_try = {drem_reg, prod_reg[PROD_W-1]};
        d_q   = (d_try >= {1'b0, den_reg});

        el_sat = (prod_reg > {3'b000, ELAPSED_CAP}) ? ELAPSED_CAP
                                                    : prod_reg[ELAPSED_W-1:0];

        sp_try = {nsr_reg, sec_reg[SEC_W-1]};
        sp_q   = (sp_try >= {1'b0, NS_PER_S});
    end

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        min_speed_next  = cfg_we ? cfg_wdata : min_speed_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        prev_speed_next = prev_speed_reg;
        elapsed_next    = elapsed_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        spd_sum_next    = spd_sum_reg;
        den_next        = den_reg;
        sqv_next        = sqv_reg;
        root_next       = root_reg;
        srem_next       = srem_reg;
        prod_next       = prod_reg;
        drem_next       = drem_reg;
        nsr_next        = nsr_reg;
        sec_next        = sec_reg;
        m_seconds_next  = m_seconds_reg;
        m_ns_next       = m_ns_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    prev_x_next     = s_x_pos;
                    prev_y_next     = s_y_pos;
                    prev_speed_next = s_speed;
                    dx_next         = x_abs;
                    dy_next         = y_abs;
                    px_next         = {{DIFF_W{1'b0}}, x_abs};
                    py_next         = {{DIFF_W{1'b0}}, y_abs};
                    spd_sum_next    = {s_speed[SPD_W-1], s_speed}
                                    + {prev_speed_reg[SPD_W-1], prev_speed_reg};
                    if (s_first) begin
                        // restart the trajectory at time zero
                        elapsed_next = '0;
                        nsr_next     = '0;
                        sec_next     = '0;
                        cnt_next     = SPLIT_CNT;
                        state_next   = ST_SPLIT;
                    end else begin
                        cnt_next   = MUL_CNT;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                // shift-add squaring, one multiplier bit a cycle
                px_next = px_reg[0] ? {px_add, px_reg[DIFF_W-1:1]}
                                    : {1'b0, px_reg[SQ_W-1:1]};
                py_next = py_reg[0] ? {py_add, py_reg[DIFF_W-1:1]}
                                    : {1'b0, py_reg[SQ_W-1:1]};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_SUMSQ;
                end
            end
            ST_SUMSQ: begin
                sqv_next   = ssq;
                root_next  = '0;
                srem_next  = '0;
                den_next   = (spd_mag > two_floor) ? spd_mag : two_floor;
                cnt_next   = SQRT_CNT;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                // one root bit per cycle from the top bit pair
                if (s_try >= s_trial) begin
                    srem_next = SREM_W'(s_try - s_trial);
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    srem_next = s_try[SREM_W-1:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                sqv_next = {sqv_reg[SSQ_W-3:0], 2'b00};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    prod_next  = {{(PROD_W-ROOT_W){1'b0}}, root_next};
                    cnt_next   = SCALE_CNT;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                prod_next = prod_reg[0] ? {sc_add, prod_reg[ROOT_W-1:1]}
                                        : {1'b0, prod_reg[PROD_W-1:1]};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    drem_next  = '0;
                    cnt_next   = DIV_CNT;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                // restoring divide, quotient shifts in behind the dividend
                drem_next = d_q ? DEN_W'(d_try - {1'b0, den_reg}) : d_try[DEN_W-1:0];
                prod_next = {prod_reg[PROD_W-2:0], d_q};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                prod_next  = {3'b000, elapsed_reg} + prod_reg;
                state_next = ST_SAT;
            end
            ST_SAT: begin
                elapsed_next = el_sat;
                nsr_next     = el_sat[ELAPSED_W-1:SEC_W];
                sec_next     = el_sat[SEC_W-1:0];
                cnt_next     = SPLIT_CNT;
                state_next   = ST_SPLIT;
            end
            ST_SPLIT: begin
                // divide by one billion, one seconds bit a cycle
                nsr_next = sp_q ? NS_W'(sp_try - {1'b0, NS_PER_S}) : sp_try[NS_W-1:0];
                sec_next = {sec_reg[SEC_W-2:0], sp_q};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_seconds_next = sec_reg;
                    m_ns_next      = nsr_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
            min_speed_reg  <= MIN_SPEED_RST;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            prev_speed_reg <= '0;
            elapsed_reg    <= '0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            m_valid_reg    <= m_valid_next;
            min_speed_reg  <= min_speed_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            prev_speed_reg <= prev_speed_next;
            elapsed_reg    <= elapsed_next;
        end
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        spd_sum_reg   <= spd_sum_next;
        den_reg       <= den_next;
        sqv_reg       <= sqv_next;
        root_reg      <= root_next;
        srem_reg      <= srem_next;
        prod_reg      <= prod_next;
        drem_reg      <= drem_next;
        nsr_reg       <= nsr_next;
        sec_reg       <= sec_next;
        m_seconds_reg <= m_seconds_next;
        m_ns_reg      <= m_ns_next;
    end

endmodule

`default_nettype wire

### rtl/tts_checker.sv
`default_nettype none
`include "trajectory_time_stamping_macros.svh"

module tts_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [tts_pkg::SEC_W-1:0]   m_seconds,
    input logic [tts_pkg::NS_W-1:0]    m_nanoseconds
);
    import tts_pkg::*;

    // nanosecond field is always a proper remainder
    `TTS_ASSERT_IMPL(a_ns_range, aclk, aresetn, m_valid, m_nanoseconds < NS_PER_S)

    // one point in flight: input closes straight after a transfer
    `TTS_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)

    // no result appears in the cycle after an input transfer
    `TTS_ASSERT_NEXT(a_no_instant_result, aclk, aresetn, s_valid && s_ready, !$rose(m_valid))

    // a stalled result holds
    `TTS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_seconds) && $stable(m_nanoseconds))

endmodule

bind trajectory_time_stamping tts_checker u_tts_checker (.*);

`default_nettype wire
